[hdl/mcrd_pkg.sv]
// Shared types and constants for the motor CAN reply decoder.
`timescale 1ns / 1ps
`default_nettype none
package mcrd_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MOTOR_ID = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOVERY_ID = 1'b1;
  localparam int ID_W = 11;

  localparam logic [ID_W-1:0] OWN_ID_RESET  = 11'd1;
  localparam logic [ID_W-1:0] DISC_ID_RESET = 11'd2047;

  // Stream widths
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 144;

  // Header types and query codes
  localparam logic [2:0] HDR_TYPE2 = 3'd2;
  localparam logic [2:0] HDR_TYPE3 = 3'd3;
  localparam logic [2:0] HDR_QUERY = 3'd5;
  localparam logic [7:0] QRY_POSITION = 8'd1;
  localparam logic [7:0] QRY_VERSION  = 8'd30;
  localparam logic [7:0] QRY_TIMEOUT  = 8'd31;
  localparam logic [7:0] QRY_BRAKE    = 8'd37;
  localparam logic [7:0] DISC_MARK0   = 8'hff;
  localparam logic [7:0] DISC_MARK2   = 8'h01;
  localparam logic [8:0] TEMP_OFFSET  = 9'd50;

  // Required data length codes
  localparam logic [3:0] DLC_FEEDBACK = 4'd8;
  localparam logic [3:0] DLC_POSITION = 4'd6;
  localparam logic [3:0] DLC_VERSION  = 4'd8;
  localparam logic [3:0] DLC_TIMEOUT  = 4'd4;
  localparam logic [3:0] DLC_BRAKE    = 4'd3;
  localparam logic [3:0] DLC_DISCOVER = 4'd5;

  typedef enum logic [2:0] {
    KIND_NONE      = 3'd0,
    KIND_TYPE2     = 3'd1,
    KIND_TYPE3     = 3'd2,
    KIND_POSITION  = 3'd3,
    KIND_VERSION   = 3'd4,
    KIND_TIMEOUT   = 3'd5,
    KIND_BRAKE     = 3'd6,
    KIND_DISCOVERY = 3'd7
  } reply_kind_t;

  typedef struct packed {
    logic [ID_W-1:0] frame_ident;
    logic            remote_flag;
    logic [3:0]      byte_count;
    logic [63:0]     payload;
  } frame_t;

  typedef struct packed {
    reply_kind_t        reply_kind;
    logic [4:0]         fault_code;
    logic [31:0]        float_bits;
    logic signed [15:0] current_centiamps;
    logic signed [8:0]  temp_half_degrees;
    logic [15:0]        comm_timeout;
    logic [23:0]        hardware_version;
    logic [23:0]        software_version;
    logic               brake_released;
    logic [ID_W-1:0]    found_motor;
  } reply_t;

endpackage
`default_nettype wire

[hdl/mcrd_decode.sv]
// Combinational classifier and field decoder for one received frame.
`timescale 1ns / 1ps
`default_nettype none
module mcrd_decode (
  input  wire mcrd_pkg::frame_t            frame,
  input  wire logic [mcrd_pkg::ID_W-1:0]   own_id,
  input  wire logic [mcrd_pkg::ID_W-1:0]   disc_id,
  output mcrd_pkg::reply_t                 reply
);

  logic [7:0]  b [8];
  logic [2:0]  hdr;
  logic        own_ok;
  logic        disc_ok;
  logic [31:0] fb_feed;
  logic [31:0] fb_pos;
  logic [15:0] disc_val;
  logic        feed_ok;
  logic        pos_ok;

  // Split payload into bytes, byte 0 highest
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      b[i] = frame.payload[63-8*i -: 8];
    end
  end

  assign hdr      = b[0][7:5];
  assign own_ok   = !frame.remote_flag && (frame.frame_ident == own_id);
  assign disc_ok  = !frame.remote_flag && (frame.frame_ident == disc_id);
  assign fb_feed  = {b[1], b[2], b[3], b[4]};
  assign fb_pos   = {b[2], b[3], b[4], b[5]};
  assign disc_val = {b[3], b[4]};
  // exponent all ones means infinity or NaN
  assign feed_ok  = (fb_feed[30:23] != 8'hff);
  assign pos_ok   = (fb_pos[30:23] != 8'hff);

  always_comb begin
    reply = '0;
    reply.reply_kind = mcrd_pkg::KIND_NONE;
    if (own_ok) begin
      if (frame.byte_count == mcrd_pkg::DLC_FEEDBACK &&
          (hdr == mcrd_pkg::HDR_TYPE2 || hdr == mcrd_pkg::HDR_TYPE3)) begin
        if (feed_ok) begin
          reply.reply_kind        = (hdr == mcrd_pkg::HDR_TYPE2) ?
                                    mcrd_pkg::KIND_TYPE2 : mcrd_pkg::KIND_TYPE3;
          reply.fault_code        = b[0][4:0];
          reply.float_bits        = fb_feed;
          reply.current_centiamps = {b[5], b[6]};
          reply.temp_half_degrees = {1'b0, b[7]} - mcrd_pkg::TEMP_OFFSET;
        end
      end else if (hdr == mcrd_pkg::HDR_QUERY) begin
        if (b[1] == mcrd_pkg::QRY_POSITION &&
            frame.byte_count == mcrd_pkg::DLC_POSITION) begin
          if (pos_ok) begin
            reply.reply_kind = mcrd_pkg::KIND_POSITION;
            reply.fault_code = b[0][4:0];
            reply.float_bits = fb_pos;
          end
        end else if (b[1] == mcrd_pkg::QRY_VERSION &&
                     frame.byte_count == mcrd_pkg::DLC_VERSION) begin
          reply.reply_kind       = mcrd_pkg::KIND_VERSION;
          reply.fault_code       = b[0][4:0];
          reply.hardware_version = {b[2], b[3], b[4]};
          reply.software_version = {b[5], b[6], b[7]};
        end else if (b[1] == mcrd_pkg::QRY_TIMEOUT &&
                     frame.byte_count == mcrd_pkg::DLC_TIMEOUT) begin
          reply.reply_kind   = mcrd_pkg::KIND_TIMEOUT;
          reply.fault_code   = b[0][4:0];
          reply.comm_timeout = {b[2], b[3]};
        end else if (b[1] == mcrd_pkg::QRY_BRAKE &&
                     frame.byte_count == mcrd_pkg::DLC_BRAKE) begin
          if (b[2][7:1] == 7'd0) begin
            reply.reply_kind     = mcrd_pkg::KIND_BRAKE;
            reply.fault_code     = b[0][4:0];
            reply.brake_released = b[2][0];
          end
        end
      end
    end

    // Discovery reply, only when nothing above matched
    if (reply.reply_kind == mcrd_pkg::KIND_NONE && disc_ok &&
        frame.byte_count == mcrd_pkg::DLC_DISCOVER &&
        b[0] == mcrd_pkg::DISC_MARK0 && b[1] == mcrd_pkg::DISC_MARK0 &&
        b[2] == mcrd_pkg::DISC_MARK2 &&
        disc_val != 16'd0 && disc_val < {5'd0, disc_id}) begin
      reply.reply_kind  = mcrd_pkg::KIND_DISCOVERY;
      reply.found_motor = disc_val[mcrd_pkg::ID_W-1:0];
    end
  end

endmodule
`default_nettype wire

[hdl/motor_can_reply_decoder.sv]
// Top level: motor CAN reply decoder with input and result registers.
// out_tvalid rises once an accepted input beat has passed the input register
// and then the result register; a stalled result register holds it back.
// Throughput: one frame per cycle unless out_tready stalls; the input register
// feeds the decode logic, whose output lands in the result register.
// Reset (rst_n low, synchronous): both stages empty, own_motor_id = 1,
// discovery_id = 2047.
`timescale 1ns / 1ps
`default_nettype none
module motor_can_reply_decoder (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // tdata: frame_ident[10:0], byte_count[14:11], payload[78:15], zero[79]
  input  wire logic [mcrd_pkg::IN_DATA_W-1:0]    in_tdata,
  // tuser: remote_flag[0]
  input  wire logic                              in_tuser,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // tdata: fault_code[4:0], float_bits[36:5], current_centiamps[52:37],
  // temp_half_degrees[61:53], comm_timeout[77:62], hardware_version[101:78],
  // software_version[125:102], brake_released[126], found_motor[137:127],
  // zero[143:138]
  output logic [mcrd_pkg::OUT_DATA_W-1:0]        out_tdata,
  // tuser: reply_kind[2:0]
  output logic [2:0]                             out_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic                              cfg_wr_en,
  input  wire logic [mcrd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mcrd_pkg::ID_W-1:0]         cfg_wdata
);

  logic [mcrd_pkg::ID_W-1:0] own_id_r;
  logic [mcrd_pkg::ID_W-1:0] disc_id_r;
  mcrd_pkg::frame_t          frame_r;
  logic                      frame_vld_r;
  mcrd_pkg::reply_t          reply_nxt;
  mcrd_pkg::reply_t          reply_r;
  logic                      out_vld_r;
  logic                      out_load;
  logic                      in_load;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r  <= mcrd_pkg::OWN_ID_RESET;
      disc_id_r <= mcrd_pkg::DISC_ID_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mcrd_pkg::CFG_OWN_MOTOR_ID: own_id_r  <= cfg_wdata;
        mcrd_pkg::CFG_DISCOVERY_ID: disc_id_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage handshakes: result register frees when empty or being taken
  assign out_load  = frame_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !frame_vld_r || out_load;
  assign in_load   = in_tvalid && in_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_vld_r <= 1'b0;
    end else if (in_tready) begin
      frame_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      frame_r.frame_ident <= in_tdata[10:0];
      frame_r.byte_count  <= in_tdata[14:11];
      frame_r.payload     <= in_tdata[78:15];
      frame_r.remote_flag <= in_tuser;
    end
  end

  // Decode
  mcrd_decode u_decode (
    .frame   (frame_r),
    .own_id  (own_id_r),
    .disc_id (disc_id_r),
    .reply   (reply_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || out_tready) begin
      out_vld_r <= frame_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      reply_r <= reply_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = reply_r.reply_kind;
  assign out_tdata  = {6'd0,
                       reply_r.found_motor,
                       reply_r.brake_released,
                       reply_r.software_version,
                       reply_r.hardware_version,
                       reply_r.comm_timeout,
                       reply_r.temp_half_degrees,
                       reply_r.current_centiamps,
                       reply_r.float_bits,
                       reply_r.fault_code};

endmodule
`default_nettype wire

[dv/reply_checker.sv]
// Checker for the motor CAN reply decoder: predicts each reply and compares it.
`timescale 1ns / 1ps
module reply_checker
  import mcrd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [IN_DATA_W-1:0]   in_tdata,
  input  wire logic                   in_tuser,
  input  wire logic                   in_tvalid,
  input  wire logic                   in_tready,
  input  wire logic [OUT_DATA_W-1:0]  out_tdata,
  input  wire logic [2:0]             out_tuser,
  input  wire logic                   out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ID_W-1:0]        cfg_wdata,
  output int                          mismatches,
  output int                          replies_pending
);

  logic [ID_W-1:0] own_motor_id;
  logic [ID_W-1:0] discovery_id;
  reply_t          expected_replies [$];

  // Classify and decode one frame against the current register copy
  function automatic reply_t decode_frame(input logic [ID_W-1:0] ident, input logic remote,
                                          input logic [3:0] dlc, input logic [63:0] p);
    logic [7:0]  b [8];
    logic [2:0]  hdr;
    logic [31:0] fl;
    logic [15:0] id16;
    reply_t      r;
    r = '0;
    for (int i = 0; i < 8; i++) b[i] = p[63 - 8 * i -: 8];
    hdr = b[0][7:5];

    if (!remote && ident == own_motor_id) begin
      if (dlc == DLC_FEEDBACK && (hdr == HDR_TYPE2 || hdr == HDR_TYPE3)) begin
        fl = {b[1], b[2], b[3], b[4]};
        // infinity and NaN are rejected
        if (fl[30:23] != 8'hff) begin
          r.reply_kind        = (hdr == HDR_TYPE2) ? KIND_TYPE2 : KIND_TYPE3;
          r.fault_code        = b[0][4:0];
          r.float_bits        = fl;
          r.current_centiamps = {b[5], b[6]};
          r.temp_half_degrees = {1'b0, b[7]} - TEMP_OFFSET;
        end
      end else if (hdr == HDR_QUERY) begin
        if (b[1] == QRY_POSITION && dlc == DLC_POSITION) begin
          fl = {b[2], b[3], b[4], b[5]};
          if (fl[30:23] != 8'hff) begin
            r.reply_kind = KIND_POSITION;
            r.fault_code = b[0][4:0];
            r.float_bits = fl;
          end
        end else if (b[1] == QRY_VERSION && dlc == DLC_VERSION) begin
          r.reply_kind       = KIND_VERSION;
          r.fault_code       = b[0][4:0];
          r.hardware_version = {b[2], b[3], b[4]};
          r.software_version = {b[5], b[6], b[7]};
        end else if (b[1] == QRY_TIMEOUT && dlc == DLC_TIMEOUT) begin
          r.reply_kind   = KIND_TIMEOUT;
          r.fault_code   = b[0][4:0];
          r.comm_timeout = {b[2], b[3]};
        end else if (b[1] == QRY_BRAKE && dlc == DLC_BRAKE) begin
          // brake byte must be 0 or 1
          if (b[2] <= 8'd1) begin
            r.reply_kind     = KIND_BRAKE;
            r.fault_code     = b[0][4:0];
            r.brake_released = b[2][0];
          end
        end
      end
    end

    // Discovery only when nothing else matched
    if (r.reply_kind == KIND_NONE && !remote && ident == discovery_id &&
        dlc == DLC_DISCOVER && b[0] == DISC_MARK0 && b[1] == DISC_MARK0 &&
        b[2] == DISC_MARK2) begin
      id16 = {b[3], b[4]};
      if (id16 != 16'd0 && id16 < {5'd0, discovery_id}) begin
        r.reply_kind  = KIND_DISCOVERY;
        r.found_motor = id16[ID_W-1:0];
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (seen !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
      mismatches++;
    end
  endtask

  initial begin
    mismatches      = 0;
    replies_pending = 0;
  end

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (!rst_n) begin
      own_motor_id = OWN_ID_RESET;
      discovery_id = DISC_ID_RESET;
      expected_replies.delete();
    end else begin
      // input beat: predict with the registers in force before any write
      if (in_tvalid && in_tready)
        expected_replies.push_back(decode_frame(in_tdata[10:0], in_tuser,
                                                in_tdata[14:11], in_tdata[78:15]));

      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_OWN_MOTOR_ID: own_motor_id = cfg_wdata;
          CFG_DISCOVERY_ID: discovery_id = cfg_wdata;
          default: ;
        endcase
      end

      // result beat
      if (out_tvalid && out_tready) begin
        got.reply_kind        = reply_kind_t'(out_tuser);
        got.fault_code        = out_tdata[4:0];
        got.float_bits        = out_tdata[36:5];
        got.current_centiamps = out_tdata[52:37];
        got.temp_half_degrees = out_tdata[61:53];
        got.comm_timeout      = out_tdata[77:62];
        got.hardware_version  = out_tdata[101:78];
        got.software_version  = out_tdata[125:102];
        got.brake_released    = out_tdata[126];
        got.found_motor       = out_tdata[137:127];
        if (expected_replies.size() == 0) begin
          $error("reply beat with no frame waiting: kind %0d", out_tuser);
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          check_field("reply_kind", want.reply_kind, got.reply_kind);
          check_field("fault_code", want.fault_code, got.fault_code);
          check_field("float_bits", want.float_bits, got.float_bits);
          check_field("current_centiamps", want.current_centiamps, got.current_centiamps);
          check_field("temp_half_degrees", want.temp_half_degrees, got.temp_half_degrees);
          check_field("comm_timeout", want.comm_timeout, got.comm_timeout);
          check_field("hardware_version", want.hardware_version, got.hardware_version);
          check_field("software_version", want.software_version, got.software_version);
          check_field("brake_released", want.brake_released, got.brake_released);
          check_field("found_motor", want.found_motor, got.found_motor);
        end
      end
    end
    replies_pending = expected_replies.size();
  end

endmodule

[dv/tb.sv]
// Testbench top for the motor CAN reply decoder: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb;
  import mcrd_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASE_FRAMES = 200;
  localparam int NUM_PHASES   = 7;
  localparam int SETTLE       = 6;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [2:0]            out_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [ID_W-1:0]       cfg_wdata;

  int              mismatches;
  int              replies_pending;
  int              cycle_count = 0;
  logic            steady;
  logic [ID_W-1:0] own_id;
  logic [ID_W-1:0] disc_id;

  // register settings per phase; the last one is drawn at random
  logic [ID_W-1:0] phase_own  [NUM_PHASES] = '{11'd2046, 11'd1, 11'd600, 11'd1365,
                                               11'd2046, 11'd1, 11'd1};
  logic [ID_W-1:0] phase_disc [NUM_PHASES] = '{11'd2047, 11'd1, 11'd600, 11'd682,
                                               11'd2, 11'd2047, 11'd2047};

  always #5 clk = ~clk;

  motor_can_reply_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  reply_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .replies_pending (replies_pending)
  );

  // Mostly short gaps, a few long ones; none in steady phases
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Mostly well-formed replies with random content, some broken, some noise
  function automatic frame_t random_frame();
    logic [7:0]  b [8];
    logic [15:0] id16;
    frame_t      f;
    int          sel;
    for (int i = 0; i < 8; i++) b[i] = 8'($urandom);
    f.frame_ident = own_id;
    f.remote_flag = 1'b0;
    f.byte_count  = '0;
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      f.frame_ident = 11'($urandom);
      f.remote_flag = 1'($urandom);
      f.byte_count  = 4'($urandom);
    end else begin
      case ($urandom_range(0, 5))
        0: begin
          f.byte_count = DLC_FEEDBACK;
          b[0][7:5] = $urandom_range(0, 1) ? HDR_TYPE3 : HDR_TYPE2;
          if ($urandom_range(0, 7) == 0) begin
            b[1][6:0] = 7'h7f;
            b[2][7]   = 1'b1;
          end
        end
        1: begin
          f.byte_count = DLC_POSITION;
          b[0][7:5] = HDR_QUERY;
          b[1] = QRY_POSITION;
          if ($urandom_range(0, 7) == 0) begin
            b[2][6:0] = 7'h7f;
            b[3][7]   = 1'b1;
          end
        end
        2: begin
          f.byte_count = DLC_VERSION;
          b[0][7:5] = HDR_QUERY;
          b[1] = QRY_VERSION;
        end
        3: begin
          f.byte_count = DLC_TIMEOUT;
          b[0][7:5] = HDR_QUERY;
          b[1] = QRY_TIMEOUT;
        end
        4: begin
          f.byte_count = DLC_BRAKE;
          b[0][7:5] = HDR_QUERY;
          b[1] = QRY_BRAKE;
          b[2] = ($urandom_range(0, 4) == 0) ? 8'($urandom) : {7'd0, 1'($urandom)};
        end
        default: begin
          f.frame_ident = disc_id;
          f.byte_count  = DLC_DISCOVER;
          b[0] = DISC_MARK0;
          b[1] = DISC_MARK0;
          b[2] = DISC_MARK2;
          case ($urandom_range(0, 7))
            0:       id16 = 16'd0;
            1:       id16 = {5'd0, disc_id};
            2:       id16 = 16'($urandom);
            3:       id16 = {5'd0, disc_id} - 16'd1;
            default: id16 = 16'($urandom_range(1, disc_id > 1 ? disc_id - 1 : 1));
          endcase
          {b[3], b[4]} = id16;
        end
      endcase
      // break one aspect of a well-formed reply
      if (sel >= 78) begin
        case ($urandom_range(0, 5))
          0:       f.byte_count  = 4'($urandom);
          1:       f.remote_flag = 1'b1;
          2:       f.frame_ident = 11'($urandom);
          3:       b[0] = 8'($urandom);
          4:       b[1] = 8'($urandom);
          default: b[2] = 8'($urandom);
        endcase
      end
    end
    f.payload = {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]};
    return f;
  endfunction

  // One input beat after a random gap; returns at the accepting edge
  task automatic send_frame(input frame_t f);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {1'b0, f.payload, f.byte_count, f.frame_ident};
    in_tuser  <= f.remote_flag;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send(input logic [ID_W-1:0] ident, input logic remote,
                      input logic [3:0] dlc, input logic [63:0] p);
    frame_t f;
    f.frame_ident = ident;
    f.remote_flag = remote;
    f.byte_count  = dlc;
    f.payload     = p;
    send_frame(f);
  endtask

  // Stop sending and wait until every reply is back, then let the pipe settle
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (replies_pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(input logic [ID_W-1:0] own, input logic [ID_W-1:0] disc);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_OWN_MOTOR_ID;
    cfg_wdata <= own;
    @(posedge clk);
    cfg_index <= CFG_DISCOVERY_ID;
    cfg_wdata <= disc;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    own_id  = own;
    disc_id = disc;
  endtask

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side flow control
  initial begin
    int stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Stimulus
  initial begin
    steady    = 1'b0;
    own_id    = OWN_ID_RESET;
    disc_id   = DISC_ID_RESET;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_OWN_MOTOR_ID;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames at the reset register values
    send(11'd1, 1'b0, 4'd8, 64'h4000_0000_0080_0000);    // type2, min current, coldest
    send(11'd1, 1'b0, 4'd8, 64'h7f7f_7fff_ff7f_ffff);    // type3, max float, hottest
    send(11'd1, 1'b0, 4'd8, 64'h4a7f_8000_0012_3480);    // type2 infinity
    send(11'd1, 1'b0, 4'd8, 64'h61ff_ffff_ff00_6464);    // type3 NaN
    send(11'd1, 1'b0, 4'd7, 64'h4000_0000_0080_0000);    // feedback short
    send(11'd1, 1'b0, 4'd15, 64'h4000_0000_0080_0000);   // length code above 8
    send(11'd1, 1'b0, 4'd6, 64'ha301_42c8_0000_55aa);    // position 100.0
    send(11'd1, 1'b0, 4'd6, 64'ha001_ff80_0000_0000);    // position -infinity
    send(11'd1, 1'b0, 4'd8, 64'ha301_42c8_0000_55aa);    // position wrong length
    send(11'd1, 1'b0, 4'd8, 64'hb51e_1234_56ab_cdef);    // version
    send(11'd1, 1'b0, 4'd8, 64'hbf1e_ffff_ff00_0000);    // version extremes
    send(11'd1, 1'b0, 4'd4, 64'ha01f_ffff_0000_0000);    // timeout max
    send(11'd1, 1'b0, 4'd4, 64'hbf1f_0000_ffff_ffff);    // timeout zero
    send(11'd1, 1'b0, 4'd3, 64'ha125_0000_0000_0000);    // brake engaged
    send(11'd1, 1'b0, 4'd3, 64'ha225_0100_0000_0000);    // brake released
    send(11'd1, 1'b0, 4'd3, 64'ha225_0200_0000_0000);    // brake byte out of range
    send(11'd1, 1'b0, 4'd6, 64'ha002_42c8_0000_0000);    // unknown query code
    send(11'd1, 1'b0, 4'd6, 64'he001_42c8_0000_0000);    // unknown header
    send(11'd1, 1'b1, 4'd8, 64'h4000_0000_0080_0000);    // remote frame
    send(11'd2, 1'b0, 4'd8, 64'h4000_0000_0080_0000);    // foreign motor
    send(11'd2047, 1'b0, 4'd5, 64'hffff_0100_0500_0000); // discovery id 5
    send(11'd2047, 1'b0, 4'd5, 64'hffff_0100_0000_0000); // discovered id zero
    send(11'd2047, 1'b0, 4'd5, 64'hffff_0107_fe00_0000); // just below discovery id
    send(11'd2047, 1'b0, 4'd5, 64'hffff_0107_ff00_0000); // equal to discovery id
    send(11'd2047, 1'b0, 4'd5, 64'hffff_01ff_ff12_3456); // far above
    send(11'd2047, 1'b0, 4'd4, 64'hffff_0100_0500_0000); // discovery wrong length
    send(11'd0, 1'b0, 4'd0, 64'h0);
    send(11'd2047, 1'b1, 4'd15, 64'hffff_ffff_ffff_ffff);
    drain();

    // Random phases, one register setting each
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == NUM_PHASES - 1) begin
        phase_own[ph]  = 11'($urandom_range(1, 2046));
        phase_disc[ph] = 11'($urandom_range(1, 2047));
      end
      write_regs(phase_own[ph], phase_disc[ph]);
      steady = (ph == 2);
      repeat (PHASE_FRAMES) send_frame(random_frame());
      drain();
    end

    if (mismatches == 0 && replies_pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

[sim.f]
hdl/mcrd_pkg.sv
hdl/mcrd_decode.sv
hdl/motor_can_reply_decoder.sv
dv/reply_checker.sv
dv/tb.sv
